// ===== hw/rtl/msie_pkg.sv =====
// Shared types, opcodes and constants for the MIPS subset executor.
package msie_pkg;

  localparam int DATA_WORDS = 1024;
  localparam int DS_AW      = $clog2(DATA_WORDS);

  localparam logic [31:0] TEXT_START_RESET = 32'h0040_0000;
  localparam logic [31:0] DATA_START_RESET = 32'h1000_0000;
  localparam logic [31:0] PC_REGION_MASK   = 32'hF000_0000;
  localparam logic [4:0]  LINK_REG         = 5'd31;

  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  typedef enum logic [1:0] {
    CFG_TEXT_START = 2'd0,
    CFG_INSTR_COUNT = 2'd1,
    CFG_DATA_START = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    OP_SPECIAL = 6'd0,
    OP_J       = 6'd2,
    OP_JAL     = 6'd3,
    OP_BEQ     = 6'd4,
    OP_BNE     = 6'd5,
    OP_ADDIU   = 6'd9,
    OP_SLTIU   = 6'd11,
    OP_ANDI    = 6'd12,
    OP_ORI     = 6'd13,
    OP_LUI     = 6'd15,
    OP_LW      = 6'd35,
    OP_SW      = 6'd43
  } opcode_t;

  typedef enum logic [5:0] {
    FN_SLL  = 6'd0,
    FN_SRL  = 6'd2,
    FN_JR   = 6'd8,
    FN_ADDU = 6'd33,
    FN_SUBU = 6'd35,
    FN_AND  = 6'd36,
    FN_OR   = 6'd37,
    FN_NOR  = 6'd39,
    FN_SLTU = 6'd43
  } funct_t;

  // Outcome of one item, carried from the execute stage to write-back.
  typedef struct packed {
    logic [31:0]      next_pc;
    logic             wr;
    logic [4:0]       widx;
    logic [31:0]      wval;
    logic             load;
    logic             store;
    logic [DS_AW-1:0] midx;
    logic [31:0]      sval;
    logic             unk;
  } exec_res_t;

endpackage

// ===== hw/rtl/msie_regfile.sv =====
// 32 x 32 register file: two registered read ports, one write port, zero after reset.
module msie_regfile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [4:0]  ra_a,
  input  logic [4:0]  ra_b,
  output logic [31:0] rd_a,
  output logic [31:0] rd_b,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd
);
  logic [31:0] mem_r [32];
  logic [31:0] valid_r;
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
  end

  // write-first: a read at the edge of a write to the same entry sees the new word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= (we && wa == ra_a) ? wd : (valid_r[ra_a] ? mem_r[ra_a] : '0);
      rd_b_r <= (we && wa == ra_b) ? wd : (valid_r[ra_b] ? mem_r[ra_b] : '0);
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// ===== hw/rtl/msie_dstore.sv =====
// Word-addressed data store, single port, registered read data.
module msie_dstore (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [msie_pkg::DS_AW-1:0] addr,
  input  logic [31:0]                wd,
  output logic [31:0]                rd
);
  import msie_pkg::*;

  logic [31:0] mem_r [DATA_WORDS];
  logic [31:0] rd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wd;
      end else begin
        rd_r <= mem_r[addr];
      end
    end
  end

  assign rd = rd_r;

endmodule

// ===== hw/rtl/msie_alu.sv =====
// Instruction decode and execute: next PC, register write, data store access.
module msie_alu (
  input  logic [31:0]          instr,
  input  logic [31:0]          pc,
  input  logic [31:0]          op_a,
  input  logic [31:0]          op_b,
  input  logic [31:0]          data_start,
  output msie_pkg::exec_res_t  res
);
  import msie_pkg::*;

  always_comb begin
    logic [4:0]  rt_f, rd_f, sh;
    logic [31:0] imm_z, imm_s, pc4, jtgt, btgt, addr, off;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;

    rt_f  = instr[20:16];
    rd_f  = instr[15:11];
    sh    = instr[10:6];
    imm_z = {16'h0000, instr[15:0]};
    imm_s = {{16{instr[15]}}, instr[15:0]};
    pc4   = pc + 32'd4;
    jtgt  = (pc4 & PC_REGION_MASK) | {4'h0, instr[25:0], 2'b00};
    btgt  = pc4 + {imm_s[29:0], 2'b00};
    addr  = op_a + imm_s;
    off   = addr - data_start;

    wr   = 1'b0;
    widx = rt_f;
    wval = '0;
    res  = '0;
    res.next_pc = pc4;

    case (opcode_t'(instr[31:26]))
      OP_SPECIAL: begin
        wr   = 1'b1;
        widx = rd_f;
        case (funct_t'(instr[5:0]))
          FN_ADDU: wval = op_a + op_b;
          FN_SUBU: wval = op_a - op_b;
          FN_AND:  wval = op_a & op_b;
          FN_OR:   wval = op_a | op_b;
          FN_NOR:  wval = ~(op_a | op_b);
          FN_SLTU: wval = {31'd0, op_a < op_b};
          FN_SLL:  wval = op_b << sh;
          FN_SRL:  wval = op_b >> sh;
          FN_JR: begin
            wr = 1'b0;
            res.next_pc = op_a;
          end
          default: begin
            wr = 1'b0;
            res.unk = 1'b1;
          end
        endcase
      end
      OP_J: res.next_pc = jtgt;
      OP_JAL: begin
        wr   = 1'b1;
        widx = LINK_REG;
        wval = pc4 + 32'd4;
        res.next_pc = jtgt;
      end
      OP_ADDIU: begin wr = 1'b1; wval = op_a + imm_s; end
      OP_ANDI:  begin wr = 1'b1; wval = op_a & imm_z; end
      OP_ORI:   begin wr = 1'b1; wval = op_a | imm_z; end
      OP_SLTIU: begin wr = 1'b1; wval = {31'd0, op_a < imm_s}; end
      OP_LUI:   begin wr = 1'b1; wval = {instr[15:0], 16'h0000}; end
      OP_BEQ: begin
        if (op_a == op_b) res.next_pc = btgt;
      end
      OP_BNE: begin
        if (op_a != op_b) res.next_pc = btgt;
      end
      OP_LW: begin
        wr = 1'b1;
        res.load = 1'b1;
        res.midx = off[DS_AW+1:2];
      end
      OP_SW: begin
        res.store = 1'b1;
        res.midx  = off[DS_AW+1:2];
        res.sval  = op_b;
      end
      default: res.unk = 1'b1;
    endcase

    // register zero is never written
    if (wr && widx != 5'd0) begin
      res.wr   = 1'b1;
      res.widx = widx;
      res.wval = wval;
    end
  end

endmodule

// ===== hw/rtl/mips_subset_instruction_executor_top.sv =====
// Top level of the MIPS subset executor: config registers, pipeline control, result register.
// Executes one MIPS32 subset instruction (or one data store preload) per input word and
// returns one result word for each. Three-stage pipeline: the accept edge reads the
// register file, the execute stage computes next PC and accesses the data store, the
// write-back stage commits the register write (load data arrives here from the store's
// registered read port) and fills the output register. A new word is taken every cycle
// while the output side keeps up. Results of the write-back stage are forwarded to the
// execute stage, so dependent instructions, loads included, run back to back.
// Configuration writes are always ready.
module mips_subset_instruction_executor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_instruction_word,
  input  logic [9:0]  in_preload_index,
  input  logic [31:0] in_preload_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_mem_write,
  output logic [9:0]  out_mem_word_index,
  output logic [31:0] out_mem_value,
  output logic        out_unknown_instruction,
  output logic        out_run_finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import msie_pkg::*;

  logic [31:0] text_start_r, text_start_nxt;
  logic [16:0] icount_r, icount_nxt;
  logic [31:0] data_start_r, data_start_nxt;
  logic [31:0] pc_r, pc_nxt;

  logic        v1_r, v1_nxt;
  logic        cmd1_r;
  logic [31:0] instr1_r;
  logic [9:0]  pidx1_r;
  logic [31:0] pval1_r;

  logic        v2_r, v2_nxt;
  exec_res_t   s2_r;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_next_pc_r;
  logic        out_reg_write_r;
  logic [4:0]  out_reg_index_r;
  logic [31:0] out_reg_value_r;
  logic        out_mem_write_r;
  logic [9:0]  out_mem_word_index_r;
  logic [31:0] out_mem_value_r;
  logic        out_unk_r;
  logic        out_fin_r;

  logic        in_acc, cfg_acc, out_adv, s2_free, s1_adv, s2_adv;
  logic [31:0] rf_a, rf_b, op_a, op_b, ld_data, fwd_val;
  logic        is_pre;
  exec_res_t   alu_res, s1_res;
  logic        ds_en, ds_we;
  logic [DS_AW-1:0] ds_addr;
  logic [31:0] ds_wd;
  logic [31:0] pc_off;
  logic        fin;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s2_free  = !v2_r || out_adv;
  assign s2_adv   = v2_r && out_adv;
  assign s1_adv   = v1_r && s2_free;
  assign in_stall = v1_r && !s2_free;
  assign in_acc   = in_valid && !in_stall;

  msie_regfile u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_acc),
    .ra_a  (in_instruction_word[25:21]),
    .ra_b  (in_instruction_word[20:16]),
    .rd_a  (rf_a),
    .rd_b  (rf_b),
    .we    (s2_adv && s2_r.wr),
    .wa    (s2_r.widx),
    .wd    (fwd_val)
  );

  // write-back stage value, visible to the execute stage before it reaches the file
  assign fwd_val = s2_r.load ? ld_data : s2_r.wval;
  assign op_a = (v2_r && s2_r.wr && s2_r.widx == instr1_r[25:21]) ? fwd_val : rf_a;
  assign op_b = (v2_r && s2_r.wr && s2_r.widx == instr1_r[20:16]) ? fwd_val : rf_b;

  msie_alu u_alu (
    .instr      (instr1_r),
    .pc         (pc_r),
    .op_a       (op_a),
    .op_b       (op_b),
    .data_start (data_start_r),
    .res        (alu_res)
  );

  assign is_pre = (cmd1_r == CMD_PRELOAD);

  always_comb begin
    s1_res = alu_res;
    if (is_pre) begin
      s1_res = '0;
      s1_res.next_pc = pc_r;
    end
  end

  assign ds_en   = s1_adv && (is_pre || alu_res.load || alu_res.store);
  assign ds_we   = is_pre || alu_res.store;
  assign ds_addr = is_pre ? DS_AW'(pidx1_r) : alu_res.midx;
  assign ds_wd   = is_pre ? pval1_r : alu_res.sval;

  msie_dstore u_ds (
    .clk  (clk),
    .en   (ds_en),
    .we   (ds_we),
    .addr (ds_addr),
    .wd   (ds_wd),
    .rd   (ld_data)
  );

  always_comb begin
    text_start_nxt = text_start_r;
    icount_nxt     = icount_r;
    data_start_nxt = data_start_r;
    pc_nxt         = pc_r;
    if (s1_adv) pc_nxt = s1_res.next_pc;
    if (cfg_acc) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEXT_START: begin
          text_start_nxt = cfg_data;
          pc_nxt         = cfg_data;
        end
        CFG_INSTR_COUNT: icount_nxt = cfg_data[16:0];
        CFG_DATA_START:  data_start_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign v1_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : v1_r);
  assign v2_nxt = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : v2_r);
  assign out_valid_nxt = out_adv ? v2_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_start_r <= TEXT_START_RESET;
      icount_r     <= '0;
      data_start_r <= DATA_START_RESET;
      pc_r         <= TEXT_START_RESET;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      text_start_r <= text_start_nxt;
      icount_r     <= icount_nxt;
      data_start_r <= data_start_nxt;
      pc_r         <= pc_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd1_r   <= in_command;
      instr1_r <= in_instruction_word;
      pidx1_r  <= in_preload_index;
      pval1_r  <= in_preload_value;
    end
    if (s1_adv) begin
      s2_r <= s1_res;
    end
  end

  assign pc_off = s2_r.next_pc - text_start_r;
  assign fin    = pc_off[31:2] >= 30'(icount_r);

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_next_pc_r        <= s2_r.next_pc;
      out_reg_write_r      <= s2_r.wr;
      out_reg_index_r      <= s2_r.widx;
      out_reg_value_r      <= s2_r.load ? (s2_r.wr ? ld_data : '0) : s2_r.wval;
      out_mem_write_r      <= s2_r.store;
      out_mem_word_index_r <= 10'(s2_r.midx);
      out_mem_value_r      <= s2_r.load ? ld_data : s2_r.sval;
      out_unk_r            <= s2_r.unk;
      out_fin_r            <= fin;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_next_pc             = out_next_pc_r;
  assign out_reg_write           = out_reg_write_r;
  assign out_reg_index           = out_reg_index_r;
  assign out_reg_value           = out_reg_value_r;
  assign out_mem_write           = out_mem_write_r;
  assign out_mem_word_index      = out_mem_word_index_r;
  assign out_mem_value           = out_mem_value_r;
  assign out_unknown_instruction = out_unk_r;
  assign out_run_finished        = out_fin_r;

endmodule

// ===== hw/rtl/msie_checker.sv =====
// Port-level checks for the MIPS subset executor, bound to the top level.
module msie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_command,
  input logic [31:0] in_instruction_word,
  input logic [9:0]  in_preload_index,
  input logic [31:0] in_preload_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_next_pc,
  input logic        out_reg_write,
  input logic [4:0]  out_reg_index,
  input logic [31:0] out_reg_value,
  input logic        out_mem_write,
  input logic [9:0]  out_mem_word_index,
  input logic [31:0] out_mem_value,
  input logic        out_unknown_instruction,
  input logic        out_run_finished,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [31:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_pc) && $stable(out_reg_value))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unknown_instruction |-> !out_reg_write && !out_mem_write)
    else $error("unknown instruction wrote state");

  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_write |-> out_reg_index != 5'd0 && !out_mem_write)
    else $error("bad register write report");

  a_idle_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_write |-> out_reg_index == 5'd0 && out_reg_value == 32'd0)
    else $error("register fields set without a write");

endmodule

bind mips_subset_instruction_executor_top msie_checker u_msie_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the MIPS subset executor: shadow core, stimulus and checks.
module tb_top;
  import msie_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 180;

  // opcode and function code ranges with no instruction behind them
  localparam logic [5:0] OP_FREE_LO = 6'd16;
  localparam logic [5:0] OP_FREE_HI = 6'd34;
  localparam logic [5:0] FN_FREE_LO = 6'd44;
  localparam logic [5:0] FN_FREE_HI = 6'd63;

  localparam funct_t ALU_FN [8] = '{FN_ADDU, FN_SUBU, FN_AND, FN_OR,
                                    FN_NOR, FN_SLTU, FN_SLL, FN_SRL};
  localparam opcode_t IMM_OP [5] = '{OP_ADDIU, OP_ANDI, OP_ORI, OP_SLTIU, OP_LUI};

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [9:0]  mem_word_index;
    logic [31:0] mem_value;
    logic        unknown_instruction;
    logic        run_finished;
  } exec_result_t;

  typedef struct {
    logic [31:0] text_s;
    logic [31:0] count;
    logic [31:0] data_s;
  } cfg_set_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

  // Shadow of the core: architectural state plus the results still owed.
  class core_shadow;
    logic [31:0]  text_base;
    logic [16:0]  n_instr;
    logic [31:0]  data_base;
    logic [31:0]  shadow_pc;
    logic [31:0]  gpr [32];
    logic [31:0]  dmem [DATA_WORDS];
    bit           dmem_set [DATA_WORDS];
    int           written [$];
    exec_result_t due_results [$];
    int mismatches, n_exec, n_preload, n_loads, n_stores, n_unknown, n_done, n_checked;

    function new();
      text_base = TEXT_START_RESET;
      shadow_pc = TEXT_START_RESET;
      n_instr   = '0;
      data_base = DATA_START_RESET;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem_set[i]) dmem_set[i] = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_TEXT_START: begin
          text_base = v;
          shadow_pc = v;
        end
        CFG_INSTR_COUNT: n_instr = v[16:0];
        CFG_DATA_START:  data_base = v;
        default: ;
      endcase
    endfunction

    function logic past_end(logic [31:0] p);
      logic [31:0] d;
      d = p - text_base;
      return (d >> 2) >= {15'd0, n_instr};
    endfunction

    function logic [9:0] word_at(logic [31:0] addr);
      logic [31:0] d;
      d = addr - data_base;
      return d[DS_AW+1:2];
    endfunction

    function void store_word(logic [9:0] k, logic [31:0] v);
      dmem[k] = v;
      if (!dmem_set[k]) begin
        dmem_set[k] = 1'b1;
        written.push_back(k);
      end
    endfunction

    function void accept_word(logic cmd, logic [31:0] iw, logic [9:0] pidx, logic [31:0] pval);
      exec_result_t r;
      logic [4:0]   rs, rt, rd, sh, widx;
      logic [5:0]   op, fn;
      logic [31:0]  a, b, imm_z, imm_s, pc4, nxt, wval;
      logic [9:0]   k;
      logic         wr;
      r = '0;
      if (cmd == CMD_PRELOAD) begin
        n_preload++;
        store_word(pidx, pval);
        r.next_pc      = shadow_pc;
        r.run_finished = past_end(shadow_pc);
      end else begin
        n_exec++;
        op = iw[31:26];
        rs = iw[25:21];
        rt = iw[20:16];
        rd = iw[15:11];
        sh = iw[10:6];
        fn = iw[5:0];
        imm_z = {16'd0, iw[15:0]};
        imm_s = {{16{iw[15]}}, iw[15:0]};
        a = gpr[rs];
        b = gpr[rt];
        pc4 = shadow_pc + 32'd4;
        nxt = pc4;
        wr = 1'b0;
        widx = '0;
        wval = '0;
        case (op)
          OP_SPECIAL: begin
            wr = 1'b1;
            widx = rd;
            case (fn)
              FN_ADDU: wval = a + b;
              FN_SUBU: wval = a - b;
              FN_AND:  wval = a & b;
              FN_OR:   wval = a | b;
              FN_NOR:  wval = ~(a | b);
              FN_SLTU: wval = {31'd0, a < b};
              FN_SLL:  wval = b << sh;
              FN_SRL:  wval = b >> sh;
              FN_JR: begin
                wr = 1'b0;
                nxt = a;
              end
              default: begin
                wr = 1'b0;
                r.unknown_instruction = 1'b1;
              end
            endcase
          end
          OP_J:  nxt = {pc4[31:28], iw[25:0], 2'b00};
          OP_JAL: begin
            wr = 1'b1;
            widx = LINK_REG;
            wval = pc4 + 32'd4;
            nxt = {pc4[31:28], iw[25:0], 2'b00};
          end
          OP_ADDIU: begin wr = 1'b1; widx = rt; wval = a + imm_s; end
          OP_ANDI:  begin wr = 1'b1; widx = rt; wval = a & imm_z; end
          OP_ORI:   begin wr = 1'b1; widx = rt; wval = a | imm_z; end
          OP_SLTIU: begin wr = 1'b1; widx = rt; wval = {31'd0, a < imm_s}; end
          OP_LUI:   begin wr = 1'b1; widx = rt; wval = {iw[15:0], 16'd0}; end
          OP_BEQ: if (a == b) nxt = pc4 + (imm_s << 2);
          OP_BNE: if (a != b) nxt = pc4 + (imm_s << 2);
          OP_LW: begin
            n_loads++;
            k = word_at(a + imm_s);
            r.mem_word_index = k;
            r.mem_value = dmem[k];
            wr = 1'b1;
            widx = rt;
            wval = dmem[k];
          end
          OP_SW: begin
            n_stores++;
            k = word_at(a + imm_s);
            store_word(k, b);
            r.mem_write = 1'b1;
            r.mem_word_index = k;
            r.mem_value = b;
          end
          default: r.unknown_instruction = 1'b1;
        endcase
        if (r.unknown_instruction) n_unknown++;
        // register zero stays zero and the write is not reported
        if (wr && widx != 5'd0) begin
          gpr[widx] = wval;
          r.reg_write = 1'b1;
          r.reg_index = widx;
          r.reg_value = wval;
        end
        shadow_pc = nxt;
        r.next_pc = nxt;
        r.run_finished = past_end(nxt);
      end
      due_results.push_back(r);
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        flag_mismatch($sformatf("result %0d %s got 0x%08h want 0x%08h",
                                n_checked, name, got, want));
    endtask

    task compare_result(exec_result_t got);
      exec_result_t want;
      if (due_results.size() == 0) begin
        flag_mismatch("result word with no expectation pending");
        return;
      end
      want = due_results.pop_front();
      check_field("next_pc", got.next_pc, want.next_pc);
      check_field("reg_write", 32'(got.reg_write), 32'(want.reg_write));
      check_field("reg_index", 32'(got.reg_index), 32'(want.reg_index));
      check_field("reg_value", got.reg_value, want.reg_value);
      check_field("mem_write", 32'(got.mem_write), 32'(want.mem_write));
      check_field("mem_word_index", 32'(got.mem_word_index), 32'(want.mem_word_index));
      check_field("mem_value", got.mem_value, want.mem_value);
      check_field("unknown_instruction", 32'(got.unknown_instruction),
                  32'(want.unknown_instruction));
      check_field("run_finished", 32'(got.run_finished), 32'(want.run_finished));
      if (want.run_finished) n_done++;
      n_checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_EXEC;
  logic [31:0] in_instruction_word = '0;
  logic [9:0]  in_preload_index = '0;
  logic [31:0] in_preload_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_next_pc;
  logic        out_reg_write;
  logic [4:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic        out_mem_write;
  logic [9:0]  out_mem_word_index;
  logic [31:0] out_mem_value;
  logic        out_unknown_instruction;
  logic        out_run_finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  core_shadow   sb = new();
  exec_result_t seen;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           n_settings = 0;
  rx_mode_t     rx_mode = RX_FREE;
  int           rx_left = 0;

  mips_subset_instruction_executor_top i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_command              (in_command),
    .in_instruction_word     (in_instruction_word),
    .in_preload_index        (in_preload_index),
    .in_preload_value        (in_preload_value),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_next_pc             (out_next_pc),
    .out_reg_write           (out_reg_write),
    .out_reg_index           (out_reg_index),
    .out_reg_value           (out_reg_value),
    .out_mem_write           (out_mem_write),
    .out_mem_word_index      (out_mem_word_index),
    .out_mem_value           (out_mem_value),
    .out_unknown_instruction (out_unknown_instruction),
    .out_run_finished        (out_run_finished),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: stretches of free flow, light and heavy stalling
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(8, 64);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
      default:  out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_next_pc, out_reg_write, out_reg_index, out_reg_value, out_mem_write,
               out_mem_word_index, out_mem_value, out_unknown_instruction,
               out_run_finished};
      sb.compare_result(seen);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] r_word(funct_t fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(opcode_t op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // LW/SW aimed at store word k from whatever rs holds; offset stays in 16-bit range
  function automatic logic [31:0] addr_word(opcode_t op, logic [4:0] rs, logic [4:0] rt,
                                            logic [9:0] k);
    logic [31:0] off;
    off = (sb.data_base + {20'd0, k, 2'b00} + 32'($urandom_range(0, 3)) - sb.gpr[rs])
          & 32'h0000_0FFF;
    off = off - 32'($urandom_range(0, 8)) * 32'd4096;
    return {op, rs, rt, off[15:0]};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  task automatic issue(logic cmd, logic [31:0] iw, logic [9:0] pidx, logic [31:0] pval);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_instruction_word <= iw;
    in_preload_index    <= pidx;
    in_preload_value    <= pval;
    do @(posedge clk); while (in_stall);
    sb.accept_word(cmd, iw, pidx, pval);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(cfg_set_t s);
    cfg_idx_t    order [3];
    logic [31:0] val [3];
    order = '{CFG_DATA_START, CFG_INSTR_COUNT, CFG_TEXT_START};
    val   = '{s.data_s, s.count, s.text_s};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(order[i], val[i]);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic next_random_word(output logic cmd, output logic [31:0] iw,
                                  output logic [9:0] pidx, output logic [31:0] pval);
    logic [4:0] rs, rt, rd;
    int sel;
    iw   = $urandom;
    pidx = 10'($urandom_range(0, 1023));
    pval = $urandom;
    cmd  = CMD_EXEC;
    rs   = pick_reg();
    rt   = pick_reg();
    rd   = pick_reg();
    sel  = $urandom_range(0, 99);
    if (sel < 8)
      cmd = CMD_PRELOAD;
    else if (sel < 18 && sb.written.size() > 0)
      // loads only touch words that hold data
      iw = addr_word(OP_LW, rs, rt, 10'(sb.written[$urandom_range(0, sb.written.size() - 1)]));
    else if (sel < 26)
      iw = addr_word(OP_SW, rs, rt, 10'($urandom_range(0, 1023)));
    else if (sel < 32)
      iw = i_word($urandom_range(0, 1) ? OP_BEQ : OP_BNE, rs,
                  ($urandom_range(0, 2) == 0) ? rs : rt,
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12) - 4));
    else if (sel < 35)
      iw = {($urandom_range(0, 1) ? OP_J : OP_JAL), iw[25:0]};
    else if (sel < 37)
      iw = r_word(FN_JR, rs, rt, rd, iw[10:6]);
    else if (sel < 41)
      iw = $urandom_range(0, 1) ? {6'($urandom_range(OP_FREE_LO, OP_FREE_HI)), iw[25:0]}
                                : {OP_SPECIAL, iw[25:6], 6'($urandom_range(FN_FREE_LO, FN_FREE_HI))};
    else if (sel < 70)
      iw = r_word(ALU_FN[$urandom_range(0, 7)], rs, rt, rd, iw[10:6]);
    else
      iw = i_word(IMM_OP[$urandom_range(0, 4)], rs, rt, iw[15:0]);
  endtask

  initial begin
    cfg_set_t    plan [PHASES];
    logic        cmd;
    logic [31:0] iw, pv;
    logic [9:0]  pi;
    plan[0] = '{32'h0040_0000, 32'd64, 32'h1000_0000};
    plan[1] = '{32'h0000_0000, 32'd0, 32'h0000_0000};
    plan[2] = '{32'hFFFF_FFFC, 32'd65536, 32'hFFFF_FFFF};
    plan[3] = '{$urandom & 32'hFFFF_FFFC, 32'($urandom_range(1, 300)), $urandom};
    plan[4] = '{$urandom, 32'd150, $urandom};
    plan[5] = '{32'h0040_0000, 32'd100, 32'h1000_0000};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    load_settings(plan[0]);
    issue(CMD_PRELOAD, 32'hFFFF_FFFF, 10'd0, 32'hFFFF_FFFF);
    issue(CMD_PRELOAD, 32'h0000_0000, 10'd1023, 32'h0000_0000);
    issue(CMD_EXEC, i_word(OP_LUI, 5'd0, 5'd1, 16'hFFFF), '0, '0);
    issue(CMD_EXEC, i_word(OP_ORI, 5'd1, 5'd1, 16'hFFFF), '0, '0);
    issue(CMD_EXEC, i_word(OP_ANDI, 5'd1, 5'd2, 16'h8000), '0, '0);
    issue(CMD_EXEC, i_word(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF), '0, '0);
    issue(CMD_EXEC, i_word(OP_ADDIU, 5'd1, 5'd0, 16'h0005), '0, '0);
    issue(CMD_EXEC, r_word(FN_ADDU, 5'd1, 5'd3, 5'd4, 5'd0), '0, '0);
    issue(CMD_EXEC, r_word(FN_SUBU, 5'd0, 5'd1, 5'd5, 5'd0), '0, '0);
    issue(CMD_EXEC, r_word(FN_AND, 5'd1, 5'd2, 5'd6, 5'd0), '0, '0);
    issue(CMD_EXEC, r_word(FN_OR, 5'd2, 5'd3, 5'd7, 5'd0), '0, '0);
    issue(CMD_EXEC, r_word(FN_NOR, 5'd0, 5'd0, 5'd8, 5'd0), '0, '0);
    issue(CMD_EXEC, r_word(FN_SLTU, 5'd0, 5'd1, 5'd9, 5'd0), '0, '0);
    issue(CMD_EXEC, r_word(FN_SLL, 5'd0, 5'd1, 5'd10, 5'd31), '0, '0);
    issue(CMD_EXEC, r_word(FN_SRL, 5'd0, 5'd1, 5'd11, 5'd31), '0, '0);
    issue(CMD_EXEC, i_word(OP_SLTIU, 5'd0, 5'd12, 16'hFFFF), '0, '0);
    issue(CMD_EXEC, addr_word(OP_SW, 5'd3, 5'd1, 10'd512), '0, '0);
    issue(CMD_EXEC, addr_word(OP_LW, 5'd1, 5'd13, 10'd1023), '0, '0);
    issue(CMD_EXEC, addr_word(OP_LW, 5'd0, 5'd14, 10'd512), '0, '0);
    issue(CMD_EXEC, i_word(OP_BEQ, 5'd0, 5'd0, 16'hFFFF), '0, '0);
    issue(CMD_EXEC, i_word(OP_BNE, 5'd0, 5'd0, 16'h7FFF), '0, '0);
    issue(CMD_EXEC, i_word(OP_BNE, 5'd1, 5'd0, 16'h8000), '0, '0);
    issue(CMD_EXEC, {OP_J, 26'h3FF_FFFF}, '0, '0);
    issue(CMD_EXEC, {OP_JAL, 26'h000_0000}, '0, '0);
    // jump to an odd address, then an unsupported word and one with a bad function code
    issue(CMD_EXEC, r_word(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0), '0, '0);
    issue(CMD_EXEC, 32'hFFFF_FFFF, '0, '0);
    issue(CMD_EXEC, {OP_SPECIAL, 20'd0, FN_FREE_HI}, '0, '0);
    issue(CMD_PRELOAD, 32'h0000_0000, 10'd3, 32'h8000_0001);

    for (int p = 1; p < PHASES; p++) begin
      settle();
      load_settings(plan[p]);
      repeat (PHASE_WORDS) begin
        next_random_word(cmd, iw, pi, pv);
        issue(cmd, iw, pi, pv);
      end
    end
    settle();

    $display("Ran %0d instructions (%0d loads, %0d stores, %0d unsupported) and %0d preloads",
             sb.n_exec, sb.n_loads, sb.n_stores, sb.n_unknown, sb.n_preload);
    $display("Checked %0d results under %0d settings, %0d past the end of the program",
             sb.n_checked, n_settings, sb.n_done);
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
